[design/pair_code_text_expander_defines.svh]
// Assertion macros shared by the expander modules.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef PAIR_CODE_TEXT_EXPANDER_DEFINES_SVH
`define PAIR_CODE_TEXT_EXPANDER_DEFINES_SVH

// Same-cycle implication.
`define PCX_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcx: same-cycle check failed");

// Next-cycle implication.
`define PCX_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcx: next-cycle check failed");

`endif

[design/pcx_pkg.sv]
`default_nettype none

package pcx_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int MAX_CODES   = 64;
    localparam int TABLE_DEPTH = 192;

    localparam int SP_W   = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(MAX_CODES + 1);
    localparam int TBL_AW = $clog2(TABLE_DEPTH);

    localparam logic [7:0] PAIR_BASE = 8'h40;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] entry_index;
        logic [7:0] left_half;
        logic [7:0] right_half;
        logic [7:0] packed_byte;
    } request_t;

    typedef struct packed {
        logic [5:0] screen_code;
        logic       message_end;
        logic       overflow;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [7:0] left_half;
        logic [7:0] right_half;
    } table_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write_entry;
        logic end_marker;
        logic init;
        logic emit_leaf;
        logic pop;
        logic read;
        logic push;
        logic finish;
        logic cut;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_leaf;
        logic count_full;
        logic stack_full;
        logic stack_empty;
    } dp_status_t;

endpackage

`default_nettype wire

[design/pair_code_text_expander.sv]
// Load requests write the dictionary and never raise busy; a zero byte gives its end marker
// in the cycle after the request. Any other decode request holds busy until the
// expansion ends, whether it finishes or is cut, and a new request is taken whenever
// busy is low. A code leaves the cycle after the next code is found; the final result
// leaves in the same cycle that busy falls. Reset clears the controller, stack pointer
// and output strobe; the dictionary has no reset value.
`default_nettype none

module pair_code_text_expander
    import pcx_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire request_t request,
    output logic          busy,
    output logic          result_valid,
    output result_t       result
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    pcx_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .status  (status),
        .busy    (busy),
        .cmd     (cmd)
    );

    pcx_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

[design/pcx_ram.sv]
`default_nettype none

module pcx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/pcx_ctrl.sv]
`default_nettype none
`include "pair_code_text_expander_defines.svh"

module pcx_ctrl
    import pcx_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire request_t   request,
    input  wire dp_status_t status,
    output logic            busy,
    output ctl_cmd_t        cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_FETCH,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   cut_reg, cut_next;
    logic   accept;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        cut_next   = cut_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (request.command == CMD_LOAD)
                    begin
                        cmd.write_entry = 1'b1;
                    end
                    else if (request.packed_byte == 8'h00)
                    begin
                        cmd.end_marker = 1'b1;
                    end
                    else
                    begin
                        cmd.init   = 1'b1;
                        cut_next   = 1'b0;
                        busy_next  = 1'b1;
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL:
            begin
                if (status.is_leaf)
                begin
                    if (status.count_full)
                    begin
                        cut_next   = 1'b1;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.emit_leaf = 1'b1;
                        if (status.stack_empty)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.pop = 1'b1;
                        end
                    end
                end
                else if (status.stack_full)
                begin
                    cut_next   = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.read   = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.push   = 1'b1;
                state_next = S_EVAL;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                cmd.cut    = cut_reg;
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            cut_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            cut_reg   <= cut_next;
        end
    end

    `PCX_ASSERT_IMP(a_fetch_after_eval, state_reg == S_FETCH, $past(state_reg) == S_EVAL)
    `PCX_ASSERT_NXT(a_decode_goes_busy, accept && request.command == CMD_DECODE && request.packed_byte != 8'h00, busy_reg)
    `PCX_ASSERT_IMP(a_busy_matches_state, 1'b1, busy_reg == (state_reg != S_IDLE))

endmodule

`default_nettype wire

[design/pcx_datapath.sv]
`default_nettype none
`include "pair_code_text_expander_defines.svh"

module pcx_datapath
    import pcx_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire request_t request,
    input  wire ctl_cmd_t cmd,
    output dp_status_t    status,
    output logic          result_valid,
    output result_t       result
);

    logic [7:0]       v_reg, v_next;
    logic [SP_W-1:0]  sp_reg, sp_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [5:0]       pend_reg, pend_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [7:0]       stk_reg [STACK_DEPTH];
    logic             result_valid_reg, result_valid_next;
    result_t          result_reg, result_next;

    logic                 tbl_we;
    logic [TBL_AW-1:0]    tbl_waddr;
    logic [TBL_AW-1:0]    tbl_raddr;
    logic [15:0]          tbl_rdata;
    table_entry_t         tbl_wentry;
    table_entry_t         tbl_rentry;
    logic [7:0]           pair_index;

    assign tbl_we     = cmd.write_entry && (request.entry_index < 8'(TABLE_DEPTH));
    assign tbl_waddr  = TBL_AW'(request.entry_index);
    assign tbl_wentry = '{left_half: request.left_half, right_half: request.right_half};
    assign pair_index = v_reg - PAIR_BASE;
    assign tbl_raddr  = TBL_AW'(pair_index);
    assign tbl_rentry = table_entry_t'(tbl_rdata);

    // Left and right halves share one row, so one lookup serves a whole pair.
    pcx_ram #(
        .WIDTH ($bits(table_entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wentry),
        .re    (cmd.read),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    assign status.is_leaf     = v_reg < PAIR_BASE;
    assign status.count_full  = count_reg == CNT_W'(MAX_CODES);
    assign status.stack_full  = ({1'b0, sp_reg} + (SP_W + 1)'(2)) > (SP_W + 1)'(STACK_DEPTH);
    assign status.stack_empty = sp_reg == '0;

    always_comb
    begin
        v_next            = v_reg;
        sp_next           = sp_reg;
        count_next        = count_reg;
        pend_next         = pend_reg;
        pend_valid_next   = pend_valid_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;

        if (cmd.init)
        begin
            v_next          = request.packed_byte;
            sp_next         = '0;
            count_next      = '0;
            pend_valid_next = 1'b0;
        end

        if (cmd.end_marker)
        begin
            result_valid_next = 1'b1;
            result_next       = '{screen_code: 6'd0, message_end: 1'b1,
                                  overflow: 1'b0, last: 1'b1};
        end

        // A code is held back one step so that the final one can carry the last flag.
        if (cmd.emit_leaf)
        begin
            if (pend_valid_reg)
            begin
                result_valid_next = 1'b1;
                result_next       = '{screen_code: pend_reg, message_end: 1'b0,
                                      overflow: 1'b0, last: 1'b0};
            end
            pend_next       = v_reg[5:0];
            pend_valid_next = 1'b1;
            count_next      = count_reg + CNT_W'(1);
        end

        if (cmd.pop)
        begin
            v_next  = stk_reg[sp_reg - SP_W'(1)];
            sp_next = sp_reg - SP_W'(1);
        end

        // The right half waits on the stack; the left half is worked on at once.
        if (cmd.push)
        begin
            v_next  = tbl_rentry.left_half;
            sp_next = sp_reg + SP_W'(1);
        end

        if (cmd.finish)
        begin
            result_valid_next = 1'b1;
            result_next       = '{screen_code: pend_valid_reg ? pend_reg : 6'd0,
                                  message_end: 1'b0, overflow: cmd.cut, last: 1'b1};
            pend_valid_next   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stk_reg[sp_reg] <= tbl_rentry.right_half;
        end
        v_reg      <= v_next;
        pend_reg   <= pend_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg           <= '0;
            count_reg        <= '0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg           <= sp_next;
            count_reg        <= count_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `PCX_ASSERT_IMP(a_count_in_range, 1'b1, count_reg <= CNT_W'(MAX_CODES))
    `PCX_ASSERT_IMP(a_overflow_on_last, result_valid_reg && result_reg.overflow, result_reg.last)
    `PCX_ASSERT_IMP(a_push_has_room, cmd.push, {1'b0, sp_reg} < (SP_W + 1)'(STACK_DEPTH - 1))

endmodule

`default_nettype wire
